// ===== hw/rtl/mesh_corner_vertex_dedup_macros.svh =====
// Assertion macros used by the checker file mcvd_checker.sv.
`ifndef MESH_CORNER_VERTEX_DEDUP_MACROS_SVH
`define MESH_CORNER_VERTEX_DEDUP_MACROS_SVH

// Implication checked on every clock, masked in reset.
`define MCVD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcvd check failed");

// Implication with the consequent checked on the next clock.
`define MCVD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcvd check failed");

`endif

// ===== hw/rtl/mcvd_pkg.sv =====
`default_nettype none
package mcvd_pkg;
  localparam int TableDepth = 1024;
  localparam int IndexBits  = 20;
  localparam int AddrBits   = $clog2(TableDepth);
  localparam int CountBits  = AddrBits + 1;
  localparam int KeyBits    = 3 * IndexBits + 2;
  localparam int RawBits    = 22;
  localparam int CntInBits  = 20;
  localparam int MinFace    = 3;
  localparam logic CmdCorner = 1'b0;
  localparam logic CmdClear  = 1'b1;

  typedef logic [KeyBits-1:0]   key_t;
  typedef logic [AddrBits-1:0]  addr_t;
  typedef logic [CountBits-1:0] count_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic clear;
    logic valid_key;
    key_t key;
    logic last;
    logic long_face;
  } job_t;

  typedef struct packed {
    logic [AddrBits-1:0] vertex_index;
    logic corner_kept;
    logic is_new;
    logic table_full;
    logic face_kept;
    logic polygon_mode;
    logic [CountBits-1:0] vertex_total;
  } res_t;

  // Resolve a raw OBJ index; returns {present, index}.
  function automatic logic [IndexBits:0] resolve(input logic signed [RawBits-1:0] raw,
                                                 input logic [CntInBits-1:0] cnt_in);
    logic [RawBits:0] cnt;
    logic signed [RawBits+1:0] idx;
    logic [RawBits:0] lim;
    lim = (RawBits+1)'(1) << IndexBits;
    cnt = ((RawBits+1)'(cnt_in) < lim) ? (RawBits+1)'(cnt_in) : lim;
    resolve = '0;
    if (raw > 0) begin
      idx = (RawBits+2)'(raw) - (RawBits+2)'(1);
      if (idx < $signed({1'b0, cnt})) resolve = {1'b1, idx[IndexBits-1:0]};
    end else if (raw < 0) begin
      idx = $signed({1'b0, cnt}) + (RawBits+2)'(raw);
      if (idx >= 0) resolve = {1'b1, idx[IndexBits-1:0]};
    end
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/mcvd_if.sv =====
`default_nettype none
interface mcvd_in_if (input wire logic clk);
  logic valid;
  logic ready;
  logic command;
  logic signed [21:0] raw_position;
  logic signed [21:0] raw_texcoord;
  logic signed [21:0] raw_normal;
  logic [19:0] position_count;
  logic [19:0] texcoord_count;
  logic [19:0] normal_count;
  logic [7:0] face_corners;
  logic last_corner;
  modport source (input clk, ready, output valid, command, raw_position, raw_texcoord,
                  raw_normal, position_count, texcoord_count, normal_count,
                  face_corners, last_corner);
  modport sink (input clk, valid, command, raw_position, raw_texcoord, raw_normal,
                position_count, texcoord_count, normal_count, face_corners,
                last_corner, output ready);
endinterface

interface mcvd_out_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [9:0] vertex_index;
  logic corner_kept;
  logic is_new;
  logic table_full;
  logic face_kept;
  logic polygon_mode;
  logic [10:0] vertex_total;
  modport source (input clk, ready, output valid, vertex_index, corner_kept, is_new,
                  table_full, face_kept, polygon_mode, vertex_total);
  modport sink (input clk, valid, vertex_index, corner_kept, is_new, table_full,
                face_kept, polygon_mode, vertex_total, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mesh_corner_vertex_dedup.sv =====
// Channel  Dir  Fields
// in_ch    in   command, raw indices, list counts, face_corners, last_corner
// out_ch   out  vertex_index, flags, polygon_mode, vertex_total
// A missing corner is looked up by scanning the stored vertex entries one entry a cycle
// through the key store's single read port; a hit ends the scan early.
// A clear, a short face or an absent position needs no scan.
// The scan does not hand over while the previous result still waits on out_ch.
// Reset is synchronous active low; the key store needs no clearing pass.
// A two-item queue lets the front accept while the back scans or stalls.
`default_nettype none
module mesh_corner_vertex_dedup
  import mcvd_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  mcvd_in_if.sink    in_ch,
  mcvd_out_if.source out_ch
);
  job_t job;
  logic job_valid, job_ready;

  mcvd_front u_front (.clk, .rst_n, .in_ch, .job_o(job), .job_valid_o(job_valid),
                      .job_ready_i(job_ready));
  mcvd_back u_back (.clk, .rst_n, .job_i(job), .job_valid_i(job_valid),
                    .job_ready_o(job_ready), .out_ch);
endmodule
`default_nettype wire

// ===== hw/rtl/mcvd_front.sv =====
`default_nettype none
module mcvd_front
  import mcvd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  mcvd_in_if.sink   in_ch,
  output job_t      job_o,
  output logic      job_valid_o,
  input  wire logic job_ready_i
);
  // Two-entry queue toward the back part
  job_t q_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic [IndexBits:0] p, t, n;
  job_t job;
  logic push, pop;

  always_comb begin
    p = resolve(in_ch.raw_position, in_ch.position_count);
    t = resolve(in_ch.raw_texcoord, in_ch.texcoord_count);
    n = resolve(in_ch.raw_normal, in_ch.normal_count);
    job.clear     = (in_ch.command == CmdClear);
    job.long_face = in_ch.face_corners >= 8'(MinFace);
    job.valid_key = p[IndexBits];
    job.last      = in_ch.last_corner;
    // absent gives 0; present gives index+1
    job.key = {(t[IndexBits] ? (IndexBits+1)'(t[IndexBits-1:0]) + 1'b1 : '0),
               (IndexBits+1)'(0), p[IndexBits-1:0]};
    job.key[KeyBits-1 -: IndexBits+1] =
      n[IndexBits] ? (IndexBits+1)'(n[IndexBits-1:0]) + 1'b1 : '0;
    job.key[2*IndexBits:IndexBits] =
      t[IndexBits] ? (IndexBits+1)'(t[IndexBits-1:0]) + 1'b1 : '0;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign job_valid_o = (cnt_r != 2'd0);
  assign pop = job_valid_o && job_ready_i;
  assign job_o = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= job;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/mcvd_back.sv =====
`default_nettype none
module mcvd_back
  import mcvd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  job_t      job_i,
  input  wire logic job_valid_i,
  output logic      job_ready_o,
  mcvd_out_if.source out_ch
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_DONE = 4'b0100, S_OUT = 4'b1000
  } state_t;

  key_t   mem [TableDepth];
  state_t state_r, state_nxt;
  job_t   job_r;
  count_t vcount_r, scan_r;
  key_t   rd_r;
  logic   rd_v_r;
  logic [7:0] fkc_r, maxc_r;
  logic   found_r;
  addr_t  hit_r;
  res_t   res_r;
  logic   out_v_r;

  // Result decision once the scan has ended
  logic kept, fresh, full;
  logic [7:0] fkc_inc;
  always_comb begin
    kept  = job_r.long_face && job_r.valid_key && (found_r || (vcount_r < count_t'(TableDepth)));
    fresh = kept && !found_r;
    full  = job_r.long_face && job_r.valid_key && !found_r &&
            (vcount_r >= count_t'(TableDepth));
    fkc_inc = (kept && fkc_r != 8'hFF) ? fkc_r + 8'd1 : fkc_r;
  end

  assign job_ready_o = (state_r == S_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.vertex_index = res_r.vertex_index;
  assign out_ch.corner_kept  = res_r.corner_kept;
  assign out_ch.is_new       = res_r.is_new;
  assign out_ch.table_full   = res_r.table_full;
  assign out_ch.face_kept    = res_r.face_kept;
  assign out_ch.polygon_mode = res_r.polygon_mode;
  assign out_ch.vertex_total = res_r.vertex_total;

  // The scan hands over only once the output register is free
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (job_valid_i) state_nxt = S_SCAN;
      S_SCAN: if ((job_r.clear || !job_r.long_face || !job_r.valid_key || found_r ||
                   (scan_r >= vcount_r && !rd_v_r)) && (!out_v_r || out_ch.ready))
                state_nxt = S_DONE;
      S_DONE: state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Store: one read port for the scan, one write at append
  always_ff @(posedge clk) begin
    rd_r <= mem[scan_r[AddrBits-1:0]];
    if (state_r == S_DONE && fresh) mem[vcount_r[AddrBits-1:0]] <= job_r.key;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) job_r <= job_i;
    if (!rst_n) begin
      state_r <= S_IDLE; vcount_r <= '0; fkc_r <= '0; maxc_r <= '0;
      out_v_r <= 1'b0; scan_r <= '0; rd_v_r <= 1'b0; found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT) out_v_r <= 1'b1;
      else if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          scan_r <= '0; rd_v_r <= 1'b0; found_r <= 1'b0;
        end
        S_SCAN: begin
          // read issued at scan_r, data checked in the following cycle
          if (scan_r < vcount_r) begin
            scan_r <= scan_r + 1'b1; rd_v_r <= 1'b1;
          end else rd_v_r <= 1'b0;
          if (rd_v_r && !found_r && rd_r == job_r.key) begin
            found_r <= 1'b1;
            hit_r <= addr_t'(scan_r - 1'b1);
          end
        end
        S_DONE: begin
          if (job_r.clear) begin
            vcount_r <= '0; fkc_r <= '0; maxc_r <= '0;
            res_r <= '0;
          end else begin
            res_r.vertex_index <= found_r ? hit_r : (fresh ? vcount_r[AddrBits-1:0] : '0);
            res_r.corner_kept  <= kept;
            res_r.is_new       <= fresh;
            res_r.table_full   <= full;
            res_r.face_kept    <= job_r.last && job_r.long_face && fkc_inc >= 8'(MinFace);
            res_r.polygon_mode <= (job_r.last && job_r.long_face && fkc_inc >= 8'(MinFace)
                                   && fkc_inc > maxc_r ? fkc_inc : maxc_r) > 8'(MinFace);
            res_r.vertex_total <= vcount_r + count_t'(fresh);
            if (fresh) vcount_r <= vcount_r + 1'b1;
            if (job_r.last) begin
              fkc_r <= '0;
              if (job_r.long_face && fkc_inc >= 8'(MinFace) && fkc_inc > maxc_r)
                maxc_r <= fkc_inc;
            end else fkc_r <= fkc_inc;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/mcvd_checker.sv =====
`default_nettype none
`include "mesh_corner_vertex_dedup_macros.svh"
module mcvd_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic corner_kept,
  input wire logic is_new,
  input wire logic table_full,
  input wire logic [10:0] vertex_total
);
  `MCVD_ASSERT_IMP(a_new_kept, clk, rst_n, out_valid && is_new, corner_kept)
  `MCVD_ASSERT_IMP(a_full_drop, clk, rst_n, out_valid && table_full, !corner_kept)
  `MCVD_ASSERT_IMP(a_total_max, clk, rst_n, out_valid, vertex_total <= 11'd1024)
  `MCVD_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind mesh_corner_vertex_dedup mcvd_checker u_chk (.clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .corner_kept(out_ch.corner_kept),
  .is_new(out_ch.is_new), .table_full(out_ch.table_full),
  .vertex_total(out_ch.vertex_total));
`default_nettype wire

// ===== tb/tb_dedup_pkg.sv =====
`timescale 1ns / 100ps
package tb_dedup_pkg;
  import mcvd_pkg::*;

  typedef struct {
    logic        command;
    logic [21:0] raw_position;
    logic [21:0] raw_texcoord;
    logic [21:0] raw_normal;
    logic [19:0] position_count;
    logic [19:0] texcoord_count;
    logic [19:0] normal_count;
    logic [7:0]  face_corners;
    logic        last_corner;
  } corner_t;

  typedef struct packed {
    logic [9:0]  vertex_index;
    logic        corner_kept;
    logic        is_new;
    logic        table_full;
    logic        face_kept;
    logic        polygon_mode;
    logic [10:0] vertex_total;
  } vtx_res_t;

  // Tracks vertex store contents and predicts one result per item sent.
  class dedup_scoreboard;
    logic [61:0] keys[TableDepth];
    int unsigned stored;
    int unsigned face_hits;
    int unsigned widest_face;
    vtx_res_t    pending[$];
    int unsigned mismatches;

    function new();
      stored = 0;
      face_hits = 0;
      widest_face = 0;
      mismatches = 0;
    endfunction

    // Returns -1 when absent, else 0-based index.
    function automatic longint idx_of(logic [21:0] raw, logic [19:0] cnt);
      longint v;
      longint c;
      v = longint'($signed(raw));
      c = longint'(cnt);
      if (v > 0) return (v - 1 < c) ? v - 1 : -1;
      if (v < 0) return (c + v >= 0) ? c + v : -1;
      return -1;
    endfunction

    function void note_corner(corner_t c);
      vtx_res_t r;
      longint p, t, n;
      logic [61:0] k;
      int unsigned i;
      bit hit;
      r = '{default: '0};
      if (c.command == CmdClear) begin
        stored = 0;
        face_hits = 0;
        widest_face = 0;
        pending = {pending, r};
        return;
      end
      if (c.face_corners >= MinFace) begin
        p = idx_of(c.raw_position, c.position_count);
        t = idx_of(c.raw_texcoord, c.texcoord_count);
        n = idx_of(c.raw_normal, c.normal_count);
        if (p >= 0) begin
          k = {21'(n + 1), 21'(t + 1), 20'(p)};
          hit = 0;
          for (i = 0; i < stored; i++) begin
            if (keys[i] == k) begin
              hit = 1;
              break;
            end
          end
          if (hit) begin
            r.vertex_index = 10'(i);
            r.corner_kept = 1;
          end else if (stored >= TableDepth) begin
            r.table_full = 1;
          end else begin
            keys[stored] = k;
            r.vertex_index = 10'(stored);
            stored++;
            r.corner_kept = 1;
            r.is_new = 1;
          end
          if (r.corner_kept && face_hits < 255) face_hits++;
        end
      end
      if (c.last_corner) begin
        if (c.face_corners >= MinFace && face_hits >= MinFace) begin
          r.face_kept = 1;
          if (face_hits > widest_face) widest_face = face_hits;
        end
        face_hits = 0;
      end
      r.polygon_mode = widest_face > MinFace;
      r.vertex_total = 11'(stored);
      pending = {pending, r};
    endfunction

    function void check_result(vtx_res_t got);
      vtx_res_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_r, got);
      end
    endfunction
  endclass
endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import mcvd_pkg::*;
  import tb_dedup_pkg::*;

  logic clk;
  logic rst_n;
  bit   calm;

  mcvd_in_if  in_ch(clk);
  mcvd_out_if out_ch(clk);

  mesh_corner_vertex_dedup dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  dedup_scoreboard sb = new();

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: random stall bursts, checks every accepted item.
  initial begin
    int stall;
    vtx_res_t r;
    out_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        r.vertex_index = out_ch.vertex_index;
        r.corner_kept = out_ch.corner_kept;
        r.is_new = out_ch.is_new;
        r.table_full = out_ch.table_full;
        r.face_kept = out_ch.face_kept;
        r.polygon_mode = out_ch.polygon_mode;
        r.vertex_total = out_ch.vertex_total;
        sb.check_result(r);
      end
      if (stall > 0) stall--;
      else if (!calm && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 9);
      out_ch.ready <= rst_n && (stall == 0);
    end
  end

  // Drive one item; random idle burst first, then hold until accepted.
  task automatic send_corner(corner_t c);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= c.command;
    in_ch.raw_position <= c.raw_position;
    in_ch.raw_texcoord <= c.raw_texcoord;
    in_ch.raw_normal <= c.raw_normal;
    in_ch.position_count <= c.position_count;
    in_ch.texcoord_count <= c.texcoord_count;
    in_ch.normal_count <= c.normal_count;
    in_ch.face_corners <= c.face_corners;
    in_ch.last_corner <= c.last_corner;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_corner(c);
  endtask

  function automatic corner_t mk(logic cmd, logic [21:0] p, logic [21:0] t,
                                 logic [21:0] n, logic [19:0] pc, logic [19:0] tc,
                                 logic [19:0] nc, logic [7:0] fc, logic lst);
    corner_t c;
    c = '{cmd, p, t, n, pc, tc, nc, fc, lst};
    return c;
  endfunction

  // Random raw index: mostly small ones of either sign, sometimes zero or any 22-bit pattern.
  function automatic logic [21:0] pick_raw(int span);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 22'($urandom);
    if (sel == 1) return 22'd0;
    if (sel < 4) return -22'($urandom_range(1, span));
    return 22'($urandom_range(1, span));
  endfunction

  // Face of random size with a small index pool so keys repeat.
  task automatic send_face(int span, logic [19:0] cnt);
    int nc, k;
    logic [7:0] fc;
    nc = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
    fc = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(nc);
    for (k = 0; k < nc; k++)
      send_corner(mk(CmdCorner, pick_raw(span), pick_raw(span), pick_raw(span),
                     cnt, cnt, cnt, fc, k == nc - 1));
  endtask

  initial begin
    int i, cnt;
    int unsigned wait_cyc;
    calm = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CmdCorner;
    in_ch.raw_position = '0;
    in_ch.raw_texcoord = '0;
    in_ch.raw_normal = '0;
    in_ch.position_count = '0;
    in_ch.texcoord_count = '0;
    in_ch.normal_count = '0;
    in_ch.face_corners = '0;
    in_ch.last_corner = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: index extremes, absent fields, short faces, clear.
    send_corner(mk(CmdCorner, 22'sd1, 22'sd0, 22'sd0, 20'hFFFFF, 20'd0, 20'd0, 8'd4, 1'b0));
    send_corner(mk(CmdCorner, 22'h200000, 22'h3FFFFF, 22'h1FFFFF, 20'hFFFFF, 20'hFFFFF,
                   20'hFFFFF, 8'd4, 1'b0));
    send_corner(mk(CmdCorner, 22'h100000, 22'h300000, 22'h100000, 20'hFFFFF, 20'hFFFFF,
                   20'hFFFFF, 8'd4, 1'b0));
    send_corner(mk(CmdCorner, 22'h3FFFFF, 22'sd5, 22'sd2, 20'd7, 20'd4, 20'd2, 8'd4, 1'b1));
    send_corner(mk(CmdCorner, 22'sd1, 22'sd1, 22'sd1, 20'd3, 20'd3, 20'd3, 8'd2, 1'b0));
    send_corner(mk(CmdCorner, 22'sd2, 22'sd1, 22'sd1, 20'd3, 20'd3, 20'd3, 8'd2, 1'b1));
    send_corner(mk(CmdCorner, 22'sd0, 22'sd1, 22'sd1, 20'd3, 20'd3, 20'd3, 8'd0, 1'b1));
    send_corner(mk(CmdCorner, 22'sd1, 22'sd1, 22'sd1, 20'd3, 20'd3, 20'd3, 8'd3, 1'b0));
    send_corner(mk(CmdCorner, 22'sd4, 22'sd1, 22'sd1, 20'd3, 20'd3, 20'd3, 8'd3, 1'b0));
    send_corner(mk(CmdCorner, 22'sd1, 22'sd1, 22'sd1, 20'd3, 20'd3, 20'd3, 8'd3, 1'b1));
    send_corner(mk(CmdCorner, 22'sd1, 22'sd1, 22'sd1, 20'd3, 20'd3, 20'd3, 8'd255, 1'b0));
    send_corner(mk(CmdCorner, 22'sd2, 22'sd1, 22'sd1, 20'd3, 20'd3, 20'd3, 8'd255, 1'b0));
    send_corner(mk(CmdCorner, 22'sd3, 22'sd1, 22'sd1, 20'd3, 20'd3, 20'd3, 8'd255, 1'b1));
    send_corner(mk(CmdClear, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 20'hFFFFF, 20'hFFFFF,
                   20'hFFFFF, 8'd255, 1'b1));

    // Fill the store to its limit, then push new keys into the full store.
    for (i = 1; i <= TableDepth + 8; i++)
      send_corner(mk(CmdCorner, 22'(i), 22'sd0, 22'sd0, 20'd2000, 20'd0, 20'd0, 8'd8,
                     (i % 8) == 0));
    send_corner(mk(CmdCorner, 22'sd5, 22'sd0, 22'sd0, 20'd2000, 20'd0, 20'd0, 8'd3, 1'b1));
    send_corner(mk(CmdClear, '0, '0, '0, '0, '0, '0, 8'd1, 1'b0));

    // Random faces on small pools, with occasional clears and raw noise.
    for (i = 0; i < 75; i++) begin
      if (i == 60) calm = 1;
      cnt = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(1, 12);
      if ($urandom_range(0, 40) == 0)
        send_corner(mk(CmdClear, 22'($urandom), 22'($urandom), 22'($urandom),
                       20'($urandom), 20'($urandom), 20'($urandom), 8'($urandom),
                       1'($urandom)));
      else if ($urandom_range(0, 15) == 0)
        send_corner(mk(CmdCorner, 22'($urandom), 22'($urandom), 22'($urandom),
                       20'($urandom), 20'($urandom), 20'($urandom), 8'($urandom),
                       1'($urandom)));
      else
        send_face($urandom_range(1, 14), 20'(cnt));
    end
    in_ch.valid <= 1'b0;

    wait_cyc = 0;
    while (sb.pending.size() != 0 && wait_cyc < 200000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (2000) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Watchdog: a corner may scan every entry of the store.
  initial begin
    #150ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mcvd_pkg.sv
hw/rtl/mcvd_if.sv
hw/rtl/mcvd_front.sv
hw/rtl/mcvd_back.sv
hw/rtl/mesh_corner_vertex_dedup.sv
hw/rtl/mcvd_checker.sv
tb/tb_dedup_pkg.sv
tb/tb_top.sv
